// ===== src/tnv_pkg.sv =====
package tnv_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] len_t;
  typedef logic [2:0]  status_t;
  typedef logic [1:0]  fault_kind_t;
  typedef logic [23:0] res_data_t;

  localparam len_t MAX_LENGTH_RESET = 16'd247;

  localparam status_t ST_VALID      = 3'd0;
  localparam status_t ST_EMPTY      = 3'd1;
  localparam status_t ST_NOT_ABS    = 3'd2;
  localparam status_t ST_ENDS_SLASH = 3'd3;
  localparam status_t ST_BAD_CHAR   = 3'd4;
  localparam status_t ST_DBL_SLASH  = 3'd5;
  localparam status_t ST_DIGIT_TOK  = 3'd6;
  localparam status_t ST_TOO_LONG   = 3'd7;

  localparam fault_kind_t FK_NONE  = 2'd0;
  localparam fault_kind_t FK_DBL   = 2'd1;
  localparam fault_kind_t FK_DIGIT = 2'd2;

  localparam byte_t CH_SLASH      = 8'h2f;
  localparam byte_t CH_UNDERSCORE = 8'h5f;
  localparam byte_t CH_DIGIT_LO   = 8'h30;
  localparam byte_t CH_DIGIT_HI   = 8'h39;
  localparam byte_t CH_UPPER_LO   = 8'h41;
  localparam byte_t CH_UPPER_HI   = 8'h5a;
  localparam byte_t CH_LOWER_LO   = 8'h61;
  localparam byte_t CH_LOWER_HI   = 8'h7a;

endpackage

// ===== src/topic_name_validator_top.sv =====
// the last byte beat passes the input and result registers to give the verdict beat
// throughput: one byte beat per cycle; a name of n bytes gives one verdict beat
// the input register keeps accepting while a verdict waits, unless its beat ends a name
// reset: synchronous, active high; clears the name state and both valid flags,
// and sets max_length to 247
module topic_name_validator_top #(
  parameter int INDEX_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  tnv_pkg::byte_t     s_tdata,   // char_byte
  input  logic               s_tlast,
  input  logic               s_tuser,   // is_empty
  output logic               m_tvalid,
  input  logic               m_tready,
  output tnv_pkg::res_data_t m_tdata,   // status[2:0], error_index[18:3], zero[23:19]
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  tnv_pkg::len_t      cfg_data   // max_length
);
  import tnv_pkg::*;

  localparam int CW = (INDEX_WIDTH > 16) ? INDEX_WIDTH : 16;

  len_t max_length;

  logic  in_valid;
  byte_t in_byte;
  logic  in_last;
  logic  in_empty;

  logic [INDEX_WIDTH-1:0] byte_count;
  logic                   prev_was_slash;
  logic                   first_not_slash;
  logic                   bad_char_seen;
  logic [INDEX_WIDTH-1:0] bad_char_pos;
  fault_kind_t            seq_kind;
  logic [INDEX_WIDTH-1:0] seq_pos;

  logic                   fns_next;
  logic                   bad_seen_next;
  logic [INDEX_WIDTH-1:0] bad_pos_next;
  fault_kind_t            seq_kind_next;
  logic [INDEX_WIDTH-1:0] seq_pos_next;
  logic [INDEX_WIDTH-1:0] count_next;

  logic is_slash, is_digit, allowed;
  logic out_free, ends_name, fire;
  logic [CW-1:0] idx_ext, bad_ext, seq_ext, lim_ext;
  status_t status;
  len_t    err_index;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid) begin
      max_length <= cfg_data;
    end
  end

  assign out_free  = !m_tvalid || m_tready;
  assign ends_name = in_last || in_empty;
  assign fire      = in_valid && (!ends_name || out_free);
  assign s_tready  = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_last  <= s_tlast;
      in_empty <= s_tuser;
    end
  end

  // per-byte checks
  always_comb begin
    is_slash = (in_byte == CH_SLASH);
    is_digit = (in_byte inside {[CH_DIGIT_LO:CH_DIGIT_HI]});
    allowed  = is_digit || is_slash || (in_byte == CH_UNDERSCORE) ||
               (in_byte inside {[CH_UPPER_LO:CH_UPPER_HI]}) ||
               (in_byte inside {[CH_LOWER_LO:CH_LOWER_HI]});

    fns_next      = (byte_count == '0) ? !is_slash : first_not_slash;
    bad_seen_next = bad_char_seen || !allowed;
    bad_pos_next  = (!allowed && !bad_char_seen) ? byte_count : bad_char_pos;

    seq_kind_next = seq_kind;
    seq_pos_next  = seq_pos;
    if (prev_was_slash && seq_kind == FK_NONE) begin
      if (is_slash) begin
        seq_kind_next = FK_DBL;
        seq_pos_next  = byte_count;
      end else if (is_digit) begin
        seq_kind_next = FK_DIGIT;
        seq_pos_next  = byte_count;
      end
    end

    count_next = (byte_count == '1) ? byte_count : byte_count + 1'b1;

    idx_ext = CW'(byte_count);
    bad_ext = CW'(bad_pos_next);
    seq_ext = CW'(seq_pos_next);
    lim_ext = CW'(max_length);

    status    = ST_VALID;
    err_index = '0;
    if (in_empty) begin
      status = ST_EMPTY;
    end else if (fns_next) begin
      status = ST_NOT_ABS;
    end else if (is_slash) begin
      status    = ST_ENDS_SLASH;
      err_index = idx_ext[15:0];
    end else if (bad_seen_next) begin
      status    = ST_BAD_CHAR;
      err_index = bad_ext[15:0];
    end else if (seq_kind_next == FK_DBL) begin
      status    = ST_DBL_SLASH;
      err_index = seq_ext[15:0];
    end else if (seq_kind_next == FK_DIGIT) begin
      status    = ST_DIGIT_TOK;
      err_index = seq_ext[15:0];
    end else if (idx_ext >= lim_ext) begin
      status    = ST_TOO_LONG;
      err_index = max_length - 16'd1;
    end
  end

  // name state
  always_ff @(posedge clk) begin
    if (rst || (fire && ends_name)) begin
      byte_count      <= '0;
      prev_was_slash  <= 1'b0;
      first_not_slash <= 1'b0;
      bad_char_seen   <= 1'b0;
      bad_char_pos    <= '0;
      seq_kind        <= FK_NONE;
      seq_pos         <= '0;
    end else if (fire) begin
      byte_count      <= count_next;
      prev_was_slash  <= is_slash;
      first_not_slash <= fns_next;
      bad_char_seen   <= bad_seen_next;
      bad_char_pos    <= bad_pos_next;
      seq_kind        <= seq_kind_next;
      seq_pos         <= seq_pos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && ends_name) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ends_name) begin
      m_tdata <= {5'd0, err_index, status};
    end
  end

endmodule

// ===== src/tnv_checker.sv =====
module tnv_checker (
  input logic               clk,
  input logic               rst,
  input logic               m_tvalid,
  input logic               m_tready,
  input tnv_pkg::res_data_t m_tdata,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input tnv_pkg::len_t      cfg_data
);
  import tnv_pkg::*;

  len_t    lim;
  status_t st;
  len_t    eidx;

  assign st   = m_tdata[2:0];
  assign eidx = m_tdata[18:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lim <= cfg_data;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("verdict beat right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled verdict beat changed");

  a_zero_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st == ST_VALID || st == ST_EMPTY || st == ST_NOT_ABS) |-> eidx == '0)
    else $error("nonzero index on a verdict without position");

  a_too_long_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st == ST_TOO_LONG |-> eidx == lim - 16'd1)
    else $error("too long verdict index does not match limit");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:19] == '0)
    else $error("verdict padding bits set");

endmodule

bind topic_name_validator_top tnv_checker u_tnv_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_data  (cfg_data)
);
